// ----- hdl/acp_pkg.sv -----
`timescale 1ns / 1ps

package acp_pkg;

    // table geometry
    localparam int BINS     = 16;
    localparam int ANTS     = 32;
    localparam int MAX_DIMS = 16;
    localparam int BIN_W    = 4;
    localparam int DIM_W    = 4;
    localparam int ANT_W    = 5;
    localparam int PH_AW    = DIM_W + BIN_W;
    localparam int CB_AW    = ANT_W + DIM_W;

    // opcodes
    localparam logic [1:0] OP_INIT   = 2'd0;
    localparam logic [1:0] OP_SELECT = 2'd1;
    localparam logic [1:0] OP_DEPOSIT = 2'd2;
    localparam logic [1:0] OP_EVAP   = 2'd3;

    // register indexes
    localparam logic [1:0] REG_DEPOSIT_AMOUNT  = 2'd0;
    localparam logic [1:0] REG_KEEP_FACTOR     = 2'd1;
    localparam logic [1:0] REG_START_PHEROMONE = 2'd2;
    localparam logic [1:0] REG_DIMS_IN_USE     = 2'd3;

    localparam logic signed [31:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

endpackage

// ----- hdl/ant_colony_pheromone_engine.sv -----
`timescale 1ns / 1ps

// Pheromone table engine for binned continuous ant colony optimization.
// Input channel s_*: one item holds an opcode and its operands; the block
// takes one item at a time (s_ready high while idle) and gives exactly one
// result item on m_* for each.
// Config channel cfg_*: always ready; write only while the block is idle.
// Work per item, from accept to result valid:
//   init      the range magnitude is divided by 15 by folding nibbles
//             (16 = 15 + 1, shift-add steps), then bin values and
//             pheromones are written for every bin
//   select    a pass summing the dimension's pheromones, then a roulette
//             walk over them (skipped if the sum is zero), a bin value read
//   deposit   48-step divide for the deposit amount,
//             then a read, read, write sequence per dimension
//   evaporate read then write for every active entry, then commit
// The pheromone memory's single read port makes each pass walk its entries.
// The result sits in an output register; while the receiver stalls the
// item waits there, and the next finished item holds the block in its done state.
// Reset (aresetn low, synchronous) restores the control and config registers
// and the best trackers; table memories stay unknown until written by init and select.

module ant_colony_pheromone_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [4:0]         s_ant,
    input  logic [3:0]         s_dimension,
    input  logic [15:0]        s_rand_frac,
    input  logic signed [31:0] s_lower_bound,
    input  logic signed [31:0] s_upper_bound,
    input  logic signed [31:0] s_fitness,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_bin_index,
    output logic signed [31:0] m_position,
    output logic signed [31:0] m_best_fitness,
    output logic [4:0]         m_best_ant,
    output logic               m_improved,
    output logic               m_saturated,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DIV      = 4'd1;
    localparam logic [3:0] ST_FILL     = 4'd2;
    localparam logic [3:0] ST_SEL_SUM  = 4'd3;
    localparam logic [3:0] ST_SEL_MUL  = 4'd4;
    localparam logic [3:0] ST_SEL_WALK = 4'd5;
    localparam logic [3:0] ST_SEL_POS  = 4'd6;
    localparam logic [3:0] ST_SEL_OUT  = 4'd7;
    localparam logic [3:0] ST_DEP_RDB  = 4'd8;
    localparam logic [3:0] ST_DEP_RDP  = 4'd9;
    localparam logic [3:0] ST_DEP_WR   = 4'd10;
    localparam logic [3:0] ST_EVA_RD   = 4'd11;
    localparam logic [3:0] ST_EVA_WR   = 4'd12;
    localparam logic [3:0] ST_DONE     = 4'd13;
    localparam logic [3:0] ST_DIV15    = 4'd14;

    logic [3:0]         state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic [4:0]         ant_reg, ant_next;
    logic [3:0]         dim_reg, dim_next;
    logic [15:0]        r_reg, r_next;
    logic signed [31:0] lower_reg, lower_next;
    logic signed [31:0] fit_reg, fit_next;
    logic               neg_reg, neg_next;
    logic [47:0]        quo_reg, quo_next;
    logic [33:0]        rem_reg, rem_next;
    logic [32:0]        dvs_reg, dvs_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [8:0]         ent_reg, ent_next;
    logic [32:0]        accq_reg, accq_next;
    logic [3:0]         accr_reg, accr_next;
    logic [35:0]        sum_reg, sum_next;
    logic [51:0]        tgt_reg, tgt_next;
    logic [35:0]        cum_reg, cum_next;
    logic [3:0]         pick_reg, pick_next;
    logic signed [31:0] pos_reg, pos_next;
    logic [3:0]         bin_reg, bin_next;
    logic               sat_reg, sat_next;
    logic               impr_reg, impr_next;
    logic [4:0]         oant_reg, oant_next;
    logic signed [31:0] gbest_reg, gbest_next;
    logic signed [31:0] ibest_reg, ibest_next;
    logic [4:0]         ibant_reg, ibant_next;
    logic [31:0]        qamt_reg, qamt_next;
    logic [15:0]        keep_reg, keep_next;
    logic [31:0]        start_reg, start_next;
    logic [4:0]         dims_reg, dims_next;
    logic               m_valid_reg, m_valid_next;
    logic [3:0]         m_bin_reg, m_bin_next;
    logic signed [31:0] m_pos_reg, m_pos_next;
    logic signed [31:0] m_best_reg, m_best_next;
    logic [4:0]         m_ant_reg, m_ant_next;
    logic               m_impr_reg, m_impr_next;
    logic               m_sat_reg, m_sat_next;

    // memory ports
    logic                      ph_we;
    logic [acp_pkg::PH_AW-1:0] ph_waddr, ph_raddr;
    logic [31:0]               ph_wdata, ph_rdata;
    logic                      bv_we;
    logic [acp_pkg::PH_AW-1:0] bv_waddr, bv_raddr;
    logic [31:0]               bv_wdata, bv_rdata;
    logic                      cb_we;
    logic [acp_pkg::CB_AW-1:0] cb_waddr, cb_raddr;
    logic [3:0]                cb_wdata, cb_rdata;

    acp_ram #(.WIDTH(32), .DEPTH(acp_pkg::BINS * acp_pkg::MAX_DIMS)) u_pheromone (
        .aclk(aclk), .we(ph_we), .waddr(ph_waddr), .wdata(ph_wdata),
        .raddr(ph_raddr), .rdata(ph_rdata)
    );

    acp_ram #(.WIDTH(32), .DEPTH(acp_pkg::BINS * acp_pkg::MAX_DIMS)) u_bin_value (
        .aclk(aclk), .we(bv_we), .waddr(bv_waddr), .wdata(bv_wdata),
        .raddr(bv_raddr), .rdata(bv_rdata)
    );

    acp_ram #(.WIDTH(4), .DEPTH(acp_pkg::ANTS * acp_pkg::MAX_DIMS)) u_chosen_bin (
        .aclk(aclk), .we(cb_we), .waddr(cb_waddr), .wdata(cb_wdata),
        .raddr(cb_raddr), .rdata(cb_rdata)
    );

    logic [4:0]         nd;
    logic               s_take;
    logic signed [32:0] range_w;
    logic [32:0]        mag_w;
    logic signed [32:0] diff_w;
    logic [32:0]        denom_w;
    logic [33:0]        rem_sh;
    logic               div_ge;
    logic [33:0]        rem_sub;
    logic [4:0]         rsum_w;
    logic [35:0]        cum_w;
    logic [33:0]        dep_sum;
    logic [47:0]        evap_prod;
    logic               out_load;

    assign nd        = (dims_reg > 5'(acp_pkg::MAX_DIMS)) ? 5'(acp_pkg::MAX_DIMS) : dims_reg;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // operand prep at accept
    assign range_w = {s_upper_bound[31], s_upper_bound} - {s_lower_bound[31], s_lower_bound};
    assign mag_w   = range_w[32] ? 33'(-range_w) : 33'(range_w);
    assign diff_w  = {s_fitness[31], s_fitness} - {gbest_reg[31], gbest_reg};
    assign denom_w = 33'd65536 + ((!diff_w[32] && diff_w != 33'sd0) ? 33'(diff_w) : 33'd0);

    // one restoring divide step
    assign rem_sh  = {rem_reg[32:0], quo_reg[47]};
    assign div_ge  = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};

    assign rsum_w    = {1'b0, accr_reg} + {1'b0, rem_reg[3:0]};
    assign cum_w     = cum_reg + {4'd0, ph_rdata};
    assign dep_sum   = {2'd0, ph_rdata} + {1'b0, quo_reg[32:0]};
    assign evap_prod = {16'd0, ph_rdata} * {32'd0, keep_reg};
    assign out_load  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        ant_next   = ant_reg;
        dim_next   = dim_reg;
        r_next     = r_reg;
        lower_next = lower_reg;
        fit_next   = fit_reg;
        neg_next   = neg_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        ent_next   = ent_reg;
        accq_next  = accq_reg;
        accr_next  = accr_reg;
        sum_next   = sum_reg;
        tgt_next   = tgt_reg;
        cum_next   = cum_reg;
        pick_next  = pick_reg;
        pos_next   = pos_reg;
        bin_next   = bin_reg;
        sat_next   = sat_reg;
        impr_next  = impr_reg;
        oant_next  = oant_reg;
        gbest_next = gbest_reg;
        ibest_next = ibest_reg;
        ibant_next = ibant_reg;
        qamt_next  = qamt_reg;
        keep_next  = keep_reg;
        start_next = start_reg;
        dims_next  = dims_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_bin_next   = m_bin_reg;
        m_pos_next   = m_pos_reg;
        m_best_next  = m_best_reg;
        m_ant_next   = m_ant_reg;
        m_impr_next  = m_impr_reg;
        m_sat_next   = m_sat_reg;
        ph_we    = 1'b0;
        ph_waddr = '0;
        ph_wdata = '0;
        ph_raddr = '0;
        bv_we    = 1'b0;
        bv_waddr = '0;
        bv_wdata = '0;
        bv_raddr = '0;
        cb_we    = 1'b0;
        cb_waddr = '0;
        cb_wdata = '0;
        cb_raddr = '0;

        // register writes
        if (cfg_valid) begin
            unique case (cfg_index)
                acp_pkg::REG_DEPOSIT_AMOUNT:  qamt_next  = cfg_data;
                acp_pkg::REG_KEEP_FACTOR:     keep_next  = cfg_data[15:0];
                acp_pkg::REG_START_PHEROMONE: start_next = cfg_data;
                acp_pkg::REG_DIMS_IN_USE:     dims_next  = cfg_data[4:0];
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    op_next    = s_opcode;
                    ant_next   = s_ant;
                    dim_next   = s_dimension;
                    r_next     = s_rand_frac;
                    lower_next = s_lower_bound;
                    fit_next   = s_fitness;
                    pick_next  = '0;
                    pos_next   = '0;
                    sat_next   = 1'b0;
                    impr_next  = 1'b0;
                    cnt_next   = '0;
                    rem_next   = '0;
                    unique case (s_opcode)
                        acp_pkg::OP_INIT: begin
                            neg_next   = range_w[32];
                            quo_next   = '0;
                            rem_next   = {1'b0, mag_w};
                            state_next = ST_DIV15;
                        end
                        acp_pkg::OP_SELECT: begin
                            sum_next   = '0;
                            state_next = ({1'b0, s_dimension} < nd) ? ST_SEL_SUM : ST_DONE;
                        end
                        acp_pkg::OP_DEPOSIT: begin
                            quo_next   = {qamt_reg, 16'd0};
                            dvs_next   = denom_w;
                            state_next = ST_DIV;
                        end
                        acp_pkg::OP_EVAP: begin
                            ent_next   = '0;
                            state_next = ST_EVA_RD;
                        end
                    endcase
                end
            end

            // range by 15: fold high nibbles into the low one, since 16 = 15 + 1
            ST_DIV15: begin
                if (rem_reg >= 34'd16) begin
                    quo_next = quo_reg + {18'd0, rem_reg[33:4]};
                    rem_next = {4'd0, rem_reg[33:4]} + {30'd0, rem_reg[3:0]};
                end else begin
                    if (rem_reg[3:0] == 4'd15) begin
                        quo_next = quo_reg + 48'd1;
                        rem_next = '0;
                    end
                    cnt_next   = '0;
                    accq_next  = '0;
                    accr_next  = '0;
                    state_next = ST_FILL;
                end
            end

            // deposit divider, one quotient bit a cycle
            ST_DIV: begin
                rem_next = div_ge ? rem_sub : rem_sh;
                quo_next = {quo_reg[46:0], div_ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd47) begin
                    cnt_next   = '0;
                    state_next = ST_DEP_RDB;
                end
            end

            // bin values by stepping quotient and remainder of i*range/15
            ST_FILL: begin
                ph_we    = 1'b1;
                ph_waddr = {dim_reg, cnt_reg[3:0]};
                ph_wdata = start_reg;
                bv_we    = 1'b1;
                bv_waddr = {dim_reg, cnt_reg[3:0]};
                bv_wdata = lower_reg + (neg_reg ? -accq_reg[31:0] : accq_reg[31:0]);
                if (rsum_w >= 5'd15) begin
                    accr_next = 4'(rsum_w - 5'd15);
                    accq_next = accq_reg + quo_reg[32:0] + 33'd1;
                end else begin
                    accr_next = rsum_w[3:0];
                    accq_next = accq_reg + quo_reg[32:0];
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg[3:0] == 4'd15) begin
                    state_next = ST_DONE;
                end
            end

            // pass one: pheromone sum
            ST_SEL_SUM: begin
                ph_raddr = {dim_reg, cnt_reg[3:0]};
                if (cnt_reg != 6'd0) begin
                    sum_next = sum_reg + {4'd0, ph_rdata};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd16) begin
                    state_next = ST_SEL_MUL;
                end
            end

            ST_SEL_MUL: begin
                tgt_next = {36'd0, r_reg} * {16'd0, sum_reg};
                cnt_next = '0;
                cum_next = '0;
                if (sum_reg == 36'd0) begin
                    pick_next  = (r_reg == 16'd0) ? 4'd0 : 4'(acp_pkg::BINS - 1);
                    state_next = ST_SEL_POS;
                end else begin
                    state_next = ST_SEL_WALK;
                end
            end

            // pass two: roulette walk
            ST_SEL_WALK: begin
                ph_raddr = {dim_reg, cnt_reg[3:0]};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg != 6'd0) begin
                    cum_next = cum_w;
                    if (tgt_reg <= {cum_w, 16'd0}) begin
                        pick_next  = 4'(cnt_reg - 6'd1);
                        state_next = ST_SEL_POS;
                    end
                end
            end

            ST_SEL_POS: begin
                bv_raddr   = {dim_reg, pick_reg};
                cb_we      = 1'b1;
                cb_waddr   = {ant_reg, dim_reg};
                cb_wdata   = pick_reg;
                state_next = ST_SEL_OUT;
            end

            ST_SEL_OUT: begin
                pos_next   = bv_rdata;
                state_next = ST_DONE;
            end

            // deposit walk over the tour
            ST_DEP_RDB: begin
                if (cnt_reg[4:0] == nd) begin
                    if (fit_reg < ibest_reg) begin
                        ibest_next = fit_reg;
                        ibant_next = ant_reg;
                    end
                    state_next = ST_DONE;
                end else begin
                    cb_raddr   = {ant_reg, cnt_reg[3:0]};
                    state_next = ST_DEP_RDP;
                end
            end

            ST_DEP_RDP: begin
                bin_next   = cb_rdata;
                ph_raddr   = {cnt_reg[3:0], cb_rdata};
                state_next = ST_DEP_WR;
            end

            ST_DEP_WR: begin
                ph_we    = 1'b1;
                ph_waddr = {cnt_reg[3:0], bin_reg};
                if (dep_sum[33:32] != 2'd0) begin
                    ph_wdata = 32'hFFFF_FFFF;
                    sat_next = 1'b1;
                end else begin
                    ph_wdata = dep_sum[31:0];
                end
                cnt_next   = cnt_reg + 6'd1;
                state_next = ST_DEP_RDB;
            end

            // evaporate every active entry, then commit
            ST_EVA_RD: begin
                if (ent_reg == {nd, 4'd0}) begin
                    oant_next = ibant_reg;
                    if (ibest_reg < gbest_reg) begin
                        gbest_next = ibest_reg;
                        impr_next  = 1'b1;
                    end
                    ibest_next = acp_pkg::MOST_POSITIVE;
                    ibant_next = '0;
                    state_next = ST_DONE;
                end else begin
                    ph_raddr   = ent_reg[7:0];
                    state_next = ST_EVA_WR;
                end
            end

            ST_EVA_WR: begin
                ph_we      = 1'b1;
                ph_waddr   = ent_reg[7:0];
                ph_wdata   = evap_prod[47:16];
                ent_next   = ent_reg + 9'd1;
                state_next = ST_EVA_RD;
            end

            // hand the result item to the output register
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_bin_next   = pick_reg;
                    m_pos_next   = pos_reg;
                    m_best_next  = gbest_reg;
                    m_ant_next   = (op_reg == acp_pkg::OP_EVAP) ? oant_reg : ibant_reg;
                    m_impr_next  = impr_reg;
                    m_sat_next   = sat_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gbest_reg   <= acp_pkg::MOST_POSITIVE;
            ibest_reg   <= acp_pkg::MOST_POSITIVE;
            ibant_reg   <= '0;
            qamt_reg    <= 32'd65536;
            keep_reg    <= 16'd58982;
            start_reg   <= 32'd65536;
            dims_reg    <= 5'd16;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gbest_reg   <= gbest_next;
            ibest_reg   <= ibest_next;
            ibant_reg   <= ibant_next;
            qamt_reg    <= qamt_next;
            keep_reg    <= keep_next;
            start_reg   <= start_next;
            dims_reg    <= dims_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        ant_reg    <= ant_next;
        dim_reg    <= dim_next;
        r_reg      <= r_next;
        lower_reg  <= lower_next;
        fit_reg    <= fit_next;
        neg_reg    <= neg_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        cnt_reg    <= cnt_next;
        ent_reg    <= ent_next;
        accq_reg   <= accq_next;
        accr_reg   <= accr_next;
        sum_reg    <= sum_next;
        tgt_reg    <= tgt_next;
        cum_reg    <= cum_next;
        pick_reg   <= pick_next;
        pos_reg    <= pos_next;
        bin_reg    <= bin_next;
        sat_reg    <= sat_next;
        impr_reg   <= impr_next;
        oant_reg   <= oant_next;
        m_bin_reg  <= m_bin_next;
        m_pos_reg  <= m_pos_next;
        m_best_reg <= m_best_next;
        m_ant_reg  <= m_ant_next;
        m_impr_reg <= m_impr_next;
        m_sat_reg  <= m_sat_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_bin_index    = m_bin_reg;
    assign m_position     = m_pos_reg;
    assign m_best_fitness = m_best_reg;
    assign m_best_ant     = m_ant_reg;
    assign m_improved     = m_impr_reg;
    assign m_saturated    = m_sat_reg;

endmodule

// ----- hdl/acp_ram.sv -----
`timescale 1ns / 1ps

module acp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [4:0]         ant;
        logic [3:0]         dimension;
        logic [15:0]        rand_frac;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
        logic signed [31:0] fitness;
    } op_item_t;

    typedef struct packed {
        logic [3:0]         bin_index;
        logic signed [31:0] position;
        logic signed [31:0] best_fitness;
        logic [4:0]         best_ant;
        logic               improved;
        logic               saturated;
    } engine_result_t;

    typedef struct {
        op_item_t       item;
        logic           typed;
        engine_result_t result;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_opcode;
    logic [4:0]         s_ant;
    logic [3:0]         s_dimension;
    logic [15:0]        s_rand_frac;
    logic signed [31:0] s_lower_bound;
    logic signed [31:0] s_upper_bound;
    logic signed [31:0] s_fitness;
    logic               m_valid;
    logic               m_ready;
    logic [3:0]         m_bin_index;
    logic signed [31:0] m_position;
    logic signed [31:0] m_best_fitness;
    logic [4:0]         m_best_ant;
    logic               m_improved;
    logic               m_saturated;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    ant_colony_pheromone_engine dut (.*);

    // predictor state
    logic [31:0]        tau_tbl [acp_pkg::BINS*acp_pkg::MAX_DIMS];
    logic signed [31:0] bval_tbl [acp_pkg::BINS*acp_pkg::MAX_DIMS];
    logic [3:0]         tour_tbl [acp_pkg::ANTS*acp_pkg::MAX_DIMS];
    logic               tour_wr [acp_pkg::ANTS*acp_pkg::MAX_DIMS];
    logic signed [31:0] glob_best;
    logic signed [31:0] iter_best;
    logic [4:0]         iter_best_ant;
    logic [31:0]        q_amount;
    logic [15:0]        keep_q;
    logic [31:0]        start_tau;
    logic [4:0]         dims_reg;

    engine_result_t pending_results[$];
    int   mismatches;
    int   s_idle_pct;
    int   r_idle_pct;
    int   hold_cycles;
    int   items_sent;
    logic hold_req = 1'b0;

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog
    initial begin
        #40ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int active_dims();
        return (dims_reg < acp_pkg::MAX_DIMS) ? int'(dims_reg) : acp_pkg::MAX_DIMS;
    endfunction

    // compute one item's result and advance the pheromone table
    function automatic engine_result_t engine_step(input op_item_t it);
        engine_result_t     res;
        int                 nd;
        longint             span;
        longint             off;
        longint             diff;
        longint unsigned    sum;
        longint unsigned    cum;
        longint unsigned    target;
        longint unsigned    denom;
        longint unsigned    delta;
        longint unsigned    v;
        int                 pick;
        int                 b;
        nd = active_dims();
        res = '0;
        res.best_ant = iter_best_ant;
        case (it.opcode)
            acp_pkg::OP_INIT: begin
                span = longint'(it.upper_bound) - longint'(it.lower_bound);
                for (int i = 0; i < acp_pkg::BINS; i++) begin
                    off = (longint'(i) * span) / longint'(acp_pkg::BINS - 1);
                    tau_tbl[it.dimension*acp_pkg::BINS + i] = start_tau;
                    bval_tbl[it.dimension*acp_pkg::BINS + i] =
                        32'(longint'(it.lower_bound) + off);
                end
            end
            acp_pkg::OP_SELECT: begin
                if (int'(it.dimension) < nd) begin
                    sum = 0;
                    cum = 0;
                    pick = acp_pkg::BINS - 1;
                    for (int i = 0; i < acp_pkg::BINS; i++)
                        sum += tau_tbl[it.dimension*acp_pkg::BINS + i];
                    target = longint'(it.rand_frac) * sum;
                    if (sum == 0) begin
                        pick = (it.rand_frac == 0) ? 0 : acp_pkg::BINS - 1;
                    end else begin
                        for (int i = 0; i < acp_pkg::BINS; i++) begin
                            cum += tau_tbl[it.dimension*acp_pkg::BINS + i];
                            if (target <= (cum << 16)) begin
                                pick = i;
                                break;
                            end
                        end
                    end
                    tour_tbl[it.ant*acp_pkg::MAX_DIMS + it.dimension] = 4'(pick);
                    tour_wr[it.ant*acp_pkg::MAX_DIMS + it.dimension] = 1'b1;
                    res.bin_index = 4'(pick);
                    res.position = bval_tbl[it.dimension*acp_pkg::BINS + pick];
                end
            end
            acp_pkg::OP_DEPOSIT: begin
                diff = longint'(it.fitness) - longint'(glob_best);
                denom = 64'd65536 + ((diff > 0) ? longint'(diff) : 64'd0);
                delta = ({32'd0, q_amount} << 16) / denom;
                for (int d = 0; d < nd; d++) begin
                    b = tour_tbl[it.ant*acp_pkg::MAX_DIMS + d];
                    v = longint'(tau_tbl[d*acp_pkg::BINS + b]) + delta;
                    if (v > 64'hFFFF_FFFF) begin
                        v = 64'hFFFF_FFFF;
                        res.saturated = 1'b1;
                    end
                    tau_tbl[d*acp_pkg::BINS + b] = v[31:0];
                end
                if (it.fitness < iter_best) begin
                    iter_best = it.fitness;
                    iter_best_ant = it.ant;
                end
                res.best_ant = iter_best_ant;
            end
            default: begin
                for (int d = 0; d < nd; d++)
                    for (int i = 0; i < acp_pkg::BINS; i++) begin
                        v = longint'(tau_tbl[d*acp_pkg::BINS + i]) * longint'(keep_q);
                        tau_tbl[d*acp_pkg::BINS + i] = v[47:16];
                    end
                if (iter_best < glob_best) begin
                    glob_best = iter_best;
                    res.improved = 1'b1;
                end
                iter_best = acp_pkg::MOST_POSITIVE;
                iter_best_ant = '0;
            end
        endcase
        res.best_fitness = glob_best;
        return res;
    endfunction

    // deposit only reads tour entries that a select has written
    function automatic logic tour_complete(input logic [4:0] ant);
        for (int d = 0; d < active_dims(); d++)
            if (!tour_wr[ant*acp_pkg::MAX_DIMS + d]) return 1'b0;
        return 1'b1;
    endfunction

    // offer one item, hold it until accepted, then log its expectation
    task automatic send_item(input op_item_t it, input logic typed, input engine_result_t res);
        engine_result_t predicted;
        if ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= it.opcode;
        s_ant         <= it.ant;
        s_dimension   <= it.dimension;
        s_rand_frac   <= it.rand_frac;
        s_lower_bound <= it.lower_bound;
        s_upper_bound <= it.upper_bound;
        s_fitness     <= it.fitness;
        do @(posedge aclk); while (!s_ready);
        predicted = engine_step(it);
        pending_results.push_back(typed ? res : predicted);
        items_sent++;
    endtask

    // valid stays high across back to back writes; the caller drops it
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            acp_pkg::REG_DEPOSIT_AMOUNT:  q_amount  = data;
            acp_pkg::REG_KEEP_FACTOR:     keep_q    = data[15:0];
            acp_pkg::REG_START_PHEROMONE: start_tau = data;
            default:                      dims_reg  = data[4:0];
        endcase
    endtask

    // block must be idle before a register write
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(4))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return $signed($urandom_range(0, 20) << 16) - 32'sh000A_0000;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic logic signed [31:0] rand_fitness();
        case ($urandom_range(3))
            0:       return glob_best;
            1:       return glob_best + $signed($urandom_range(0, 200000)) - 32'sd100000;
            2:       return ($urandom_range(1)) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic op_item_t random_noise();
        op_item_t it;
        it.opcode      = 2'($urandom_range(3));
        it.ant         = 5'($urandom());
        it.dimension   = 4'($urandom());
        it.rand_frac   = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom());
        it.lower_bound = rand_value();
        it.upper_bound = rand_value();
        it.fitness     = rand_fitness();
        if (it.opcode == acp_pkg::OP_DEPOSIT && !tour_complete(it.ant))
            it.opcode = acp_pkg::OP_SELECT;
        return it;
    endfunction

    // well-formed iteration: tours, deposits, then evaporate and commit
    task automatic colony_round();
        op_item_t it;
        int nants;
        logic [4:0] ants [4];
        nants = $urandom_range(1, 4);
        for (int a = 0; a < nants; a++) begin
            ants[a] = 5'($urandom());
            for (int d = 0; d < active_dims(); d++) begin
                it = random_noise();
                it.opcode = acp_pkg::OP_SELECT;
                it.ant = ants[a];
                it.dimension = 4'(d);
                send_item(it, 1'b0, '0);
            end
        end
        for (int a = 0; a < nants; a++) begin
            it = random_noise();
            it.opcode = acp_pkg::OP_DEPOSIT;
            it.ant = ants[a];
            send_item(it, 1'b0, '0);
        end
        it = random_noise();
        it.opcode = acp_pkg::OP_EVAP;
        send_item(it, 1'b0, '0);
    endtask

    // result checking and receiver stalls
    initial begin
        engine_result_t want;
        engine_result_t got;
        logic           hold_taken;
        hold_taken = 1'b0;
        forever begin
            if (hold_req && !hold_taken) begin
                hold_cycles = 600;
                hold_taken  = 1'b1;
            end
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= r_idle_pct);
            end
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = '{m_bin_index, m_position, m_best_fitness, m_best_ant,
                        m_improved, m_saturated};
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result item %p", got);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at %0t: expected %p, got %p", $realtime, want, got);
                    end
                end
            end
        end
    end

    // stimulus
    initial begin
        stim_row_t rows[$];
        stim_row_t row;
        engine_result_t reset_res;
        op_item_t it;
        logic [31:0] phase_cfg [5][4];
        int limit;

        mismatches = 0;
        items_sent = 0;
        s_idle_pct = 8;
        r_idle_pct = 82;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_opcode <= acp_pkg::OP_INIT;
        s_ant <= '0;
        s_dimension <= '0;
        s_rand_frac <= '0;
        s_lower_bound <= '0;
        s_upper_bound <= '0;
        s_fitness <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= acp_pkg::REG_DEPOSIT_AMOUNT;
        cfg_data <= '0;
        for (int i = 0; i < acp_pkg::ANTS*acp_pkg::MAX_DIMS; i++) tour_wr[i] = 1'b0;
        glob_best = acp_pkg::MOST_POSITIVE;
        iter_best = acp_pkg::MOST_POSITIVE;
        iter_best_ant = '0;
        q_amount = 32'd65536;
        keep_q = 16'd58982;
        start_tau = 32'd65536;
        dims_reg = 5'd16;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows: init every dimension, bound extremes first
        reset_res = '{4'd0, 32'sd0, acp_pkg::MOST_POSITIVE, 5'd0, 1'b0, 1'b0};
        for (int d = 0; d < acp_pkg::MAX_DIMS; d++) begin
            row.item = '{acp_pkg::OP_INIT, 5'd0, 4'(d), 16'd0, -32'sd5 <<< 16,
                         32'sd5 <<< 16, 32'sd0};
            if (d == 0) begin
                row.item.lower_bound = 32'sh8000_0000;
                row.item.upper_bound = 32'sh7FFF_FFFF;
            end else if (d == 1) begin
                row.item.lower_bound = 32'sh7FFF_FFFF;
                row.item.upper_bound = 32'sh8000_0000;
            end else if (d == 2) begin
                row.item.lower_bound = 32'sd0;
                row.item.upper_bound = 32'sd0;
            end
            row.typed = 1'b1;
            row.result = reset_res;
            rows.push_back(row);
        end
        // zero fraction picks the first bin, whose value is the lower bound
        row.item = '{acp_pkg::OP_SELECT, 5'd0, 4'd0, 16'd0, 32'sd0, 32'sd0, 32'sd0};
        row.result = '{4'd0, 32'sh8000_0000, acp_pkg::MOST_POSITIVE, 5'd0, 1'b0, 1'b0};
        rows.push_back(row);
        row.typed = 1'b0;
        row.item = '{acp_pkg::OP_SELECT, 5'd0, 4'd1, 16'hFFFF, 32'sd0, 32'sd0, 32'sd0};
        rows.push_back(row);
        row.item = '{acp_pkg::OP_SELECT, 5'd31, 4'd15, 16'h8000, 32'sd0, 32'sd0, 32'sd0};
        rows.push_back(row);
        row.item = '{acp_pkg::OP_EVAP, 5'd0, 4'd0, 16'd0, 32'sd0, 32'sd0, 32'sd0};
        row.typed = 1'b1;
        row.result = reset_res;
        rows.push_back(row);
        foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].result);

        // register settings per phase: amount, keep, start, dims
        phase_cfg[0] = '{32'd65536, 32'd58982, 32'd65536, 32'd16};
        phase_cfg[1] = '{32'hFFFF_FFFF, 32'd65535, 32'hFFFF_FFFF, 32'd1};
        phase_cfg[2] = '{32'd0, 32'd0, 32'd0, 32'd0};
        phase_cfg[3] = '{$urandom(), 32'($urandom_range(65535)),
                         32'($urandom_range(1 << 24)), 32'd31};
        phase_cfg[4] = '{32'd4096, 32'd60000, 32'd65536, 32'd5};

        for (int p = 0; p < 5; p++) begin
            drain();
            for (int r = 0; r < 4; r++) write_reg(2'(r), phase_cfg[p][r]);
            cfg_valid <= 1'b0;
            if (p == 2) begin
                s_idle_pct = 82;
                r_idle_pct = 8;
            end else if (p == 4) begin
                s_idle_pct = 0;
                r_idle_pct = 0;
            end
            // refresh a few dimensions under the new start value, all when it is zero
            for (int d = 0; d < acp_pkg::MAX_DIMS; d++)
                if (p == 2 || $urandom_range(3) == 0) begin
                    it = random_noise();
                    it.opcode = acp_pkg::OP_INIT;
                    it.dimension = 4'(d);
                    send_item(it, 1'b0, '0);
                end
            limit = items_sent + 320;
            while (items_sent < limit) begin
                // long receiver hold while items keep coming
                if (p == 3 && items_sent > limit - 200)
                    hold_req = 1'b1;
                if ($urandom_range(99) < 65) colony_round();
                else send_item(random_noise(), 1'b0, '0);
            end
        end

        // drain and settle
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/acp_pkg.sv
hdl/acp_ram.sv
hdl/ant_colony_pheromone_engine.sv
test/tb_top.sv
